[design/spa_pkg.sv]
// Shared types, codes and widths of the sparse polynomial accumulator.
`default_nettype none

package spa_pkg;

    localparam int MAX_TERMS_DEFAULT = 16;
    localparam int COEF_W            = 32;
    localparam int EXP_W             = 8;
    localparam int OP_W              = 2;
    localparam int STATUS_W          = 2;
    localparam int TDATA_W           = 40;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic        [EXP_W-1:0]  exp_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_RSVD  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SEL,
        S_ADD_SUM,
        S_ADD_WB,
        S_READ_CHK,
        S_READ,
        S_READ_SPIN,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        EMIT_ADD,
        EMIT_TERM,
        EMIT_EMPTY,
        EMIT_OK
    } emit_kind_t;

    typedef struct packed {
        logic       load;
        logic       add_select;
        logic       add_sum;
        logic       add_write;
        logic       rotate;
        logic       clear;
        logic       emit;
        emit_kind_t emit_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic table_empty;
        logic read_last;
        logic spin_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[design/sparse_polynomial_accumulator_unit.sv]
// Top level of the sparse polynomial accumulator: sequencer plus term datapath.
//
//  Channel | Dir | tdata (low bit up)                    | tuser       | tlast
//  s_      | in  | coefficient[31:0], exponent[39:32]    | op[1:0]     | -
//  m_      | out | term_coefficient[31:0], term_exponent | status[1:0] | last
//
// An add steps through accept, select the matching cell, saturating add, and write
// back and emit; each step is registered, and the next beat can be taken in the
// same cycle the result is valid. A read-out checks the table, then emits one
// stored term per rotation of the cell chain, which keeps rotating until MAX_TERMS
// shifts in all have put it back in order before the next beat is taken. Clear and
// the unused op are answered from the response state. Reset is synchronous and
// active low and empties the table; stored terms are not cleared. A stalled m_ side
// holds the sequencer only where it has a new beat to hand over.
`default_nettype none

module sparse_polynomial_accumulator_unit #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [spa_pkg::TDATA_W-1:0] s_tdata,   // coefficient[31:0], exponent[39:32]
    input  logic [1:0]                  s_tuser,   // op[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [spa_pkg::TDATA_W-1:0] m_tdata,   // term_coefficient[31:0], term_exponent[39:32]
    output logic [1:0]                  m_tuser,   // status[1:0]
    output logic                        m_tlast
);

    spa_pkg::ctrl_cmd_t  cmd;
    spa_pkg::dp_status_t dp_status;

    // The sequencer decodes the op and steps through the add, read-out and
    // response phases; it sees the datapath only through cmd and dp_status.
    spa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (dp_status),
        .cmd      (cmd)
    );

    // The datapath keeps the terms sorted by exponent in a chain of cells, so a
    // read-out is a rotation of the chain with the head cell feeding the output.
    spa_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (dp_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // Only read-out beats come in runs; every other beat closes its run.
    a_mid_beat_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == spa_pkg::ST_OK)
        else $error("non-final beat with a flag status");

    // A flagged beat carries no term.
    a_flag_no_term: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != spa_pkg::ST_OK |-> m_tdata == '0)
        else $error("flagged beat with term data");

    // Each accepted beat is worked on alone before the next is taken.
    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a beat is in work");

    // The chain never rotates during an add write-back.
    a_no_mixed_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add_write |-> !cmd.rotate && !cmd.clear)
        else $error("cell chain written two ways at once");
`endif

endmodule

`default_nettype wire

[design/spa_ctrl.sv]
// Sequencer of the sparse polynomial accumulator: accepts beats and steps the datapath.
`default_nettype none

module spa_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             s_tuser,
    input  spa_pkg::dp_status_t    status,
    output spa_pkg::ctrl_cmd_t     cmd
);

    spa_pkg::state_t state_reg, state_next;
    spa_pkg::op_t    op_reg, op_next;
    spa_pkg::op_t    op_in;

    assign op_in = spa_pkg::op_t'(s_tuser);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spa_pkg::S_IDLE;
            op_reg    <= spa_pkg::OP_ADD;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.emit_kind = spa_pkg::EMIT_OK;
        unique case (state_reg)
            spa_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    op_next  = op_in;
                    case (op_in) inside
                        spa_pkg::OP_ADD:                   state_next = spa_pkg::S_ADD_SEL;
                        spa_pkg::OP_READ:                  state_next = spa_pkg::S_READ_CHK;
                        spa_pkg::OP_CLEAR, spa_pkg::OP_RSVD: state_next = spa_pkg::S_RESP;
                        default:                           state_next = spa_pkg::S_RESP;
                    endcase
                end
            end
            spa_pkg::S_ADD_SEL: begin
                cmd.add_select = 1'b1;
                state_next     = spa_pkg::S_ADD_SUM;
            end
            spa_pkg::S_ADD_SUM: begin
                cmd.add_sum = 1'b1;
                state_next  = spa_pkg::S_ADD_WB;
            end
            spa_pkg::S_ADD_WB: begin
                if (status.out_free) begin
                    cmd.add_write = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = spa_pkg::EMIT_ADD;
                    state_next    = spa_pkg::S_IDLE;
                end
            end
            spa_pkg::S_READ_CHK: begin
                if (!status.table_empty) begin
                    state_next = spa_pkg::S_READ;
                end else if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = spa_pkg::EMIT_EMPTY;
                    state_next    = spa_pkg::S_IDLE;
                end
            end
            spa_pkg::S_READ: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = spa_pkg::EMIT_TERM;
                    cmd.rotate    = 1'b1;
                    if (status.read_last) begin
                        state_next = status.spin_done ? spa_pkg::S_IDLE : spa_pkg::S_READ_SPIN;
                    end
                end
            end
            spa_pkg::S_READ_SPIN: begin
                // Finish the full turn of the chain so the order is restored.
                cmd.rotate = 1'b1;
                if (status.spin_done) begin
                    state_next = spa_pkg::S_IDLE;
                end
            end
            spa_pkg::S_RESP: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = spa_pkg::EMIT_OK;
                    cmd.clear     = (op_reg == spa_pkg::OP_CLEAR);
                    state_next    = spa_pkg::S_IDLE;
                end
            end
            default: state_next = spa_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[design/spa_datapath.sv]
// Sorted term chain, saturating adder and output register of the accumulator.
`default_nettype none

module spa_datapath #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [spa_pkg::TDATA_W-1:0] s_tdata,
    input  spa_pkg::ctrl_cmd_t          cmd,
    output spa_pkg::dp_status_t         status,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [spa_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = $clog2(MAX_TERMS);

    spa_pkg::coef_t  coef_in_reg;
    spa_pkg::exp_t   exp_in_reg;

    // Chain of cells, kept sorted by descending exponent below count_reg.
    spa_pkg::coef_t  cell_coef_reg  [MAX_TERMS];
    spa_pkg::exp_t   cell_exp_reg   [MAX_TERMS];
    spa_pkg::coef_t  cell_coef_next [MAX_TERMS];
    spa_pkg::exp_t   cell_exp_next  [MAX_TERMS];

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [MAX_TERMS-1:0] match_reg, match_next;
    logic [MAX_TERMS-1:0] gt, gt_prev;
    spa_pkg::coef_t       sel_coef_reg, sel_coef_next;
    spa_pkg::coef_t       sum_reg;
    logic                 sat_reg;
    logic signed [spa_pkg::COEF_W:0] wide_sum;
    logic                 found, table_full;

    spa_pkg::coef_t   out_coef_reg;
    spa_pkg::exp_t    out_exp_reg;
    spa_pkg::status_t out_status_reg;
    logic             out_last_reg;
    logic             out_valid_reg;

    assign found      = |match_reg;
    assign table_full = (count_reg == CNT_W'(MAX_TERMS));

    // Per-cell compares against the held exponent.
    always_comb begin
        for (int i = 0; i < MAX_TERMS; i++) begin
            match_next[i] = (CNT_W'(i) < count_reg) && (cell_exp_reg[i] == exp_in_reg);
            gt[i]         = (CNT_W'(i) < count_reg) && (cell_exp_reg[i] > exp_in_reg);
        end
        gt_prev = {gt[MAX_TERMS-2:0], 1'b1};
    end

    always_comb begin
        sel_coef_next = '0;
        for (int i = 0; i < MAX_TERMS; i++) begin
            sel_coef_next = sel_coef_next | (match_next[i] ? cell_coef_reg[i] : '0);
        end
    end

    assign wide_sum = {sel_coef_reg[spa_pkg::COEF_W-1], sel_coef_reg}
                    + {coef_in_reg[spa_pkg::COEF_W-1], coef_in_reg};

    always_comb begin
        int nxt;
        int prv;
        for (int i = 0; i < MAX_TERMS; i++) begin
            nxt = (i == MAX_TERMS - 1) ? 0 : i + 1;
            prv = (i == 0) ? 0 : i - 1;
            cell_coef_next[i] = cell_coef_reg[i];
            cell_exp_next[i]  = cell_exp_reg[i];
            if (cmd.rotate) begin
                cell_coef_next[i] = cell_coef_reg[nxt];
                cell_exp_next[i]  = cell_exp_reg[nxt];
            end else if (cmd.add_write) begin
                if (found) begin
                    if (match_reg[i]) begin
                        cell_coef_next[i] = sum_reg;
                    end
                end else if (!table_full && (CNT_W'(i) <= count_reg) && !gt[i]) begin
                    // Cells below the insertion point move down by one.
                    if (gt_prev[i]) begin
                        cell_coef_next[i] = coef_in_reg;
                        cell_exp_next[i]  = exp_in_reg;
                    end else begin
                        cell_coef_next[i] = cell_coef_reg[prv];
                        cell_exp_next[i]  = cell_exp_reg[prv];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_TERMS; i++) begin
            cell_coef_reg[i] <= cell_coef_next[i];
            cell_exp_reg[i]  <= cell_exp_next[i];
        end
        if (cmd.load) begin
            coef_in_reg <= s_tdata[spa_pkg::COEF_W-1:0];
            exp_in_reg  <= s_tdata[spa_pkg::COEF_W +: spa_pkg::EXP_W];
        end
        if (cmd.add_select) begin
            match_reg    <= match_next;
            sel_coef_reg <= sel_coef_next;
        end
        if (cmd.add_sum) begin
            sat_reg <= (wide_sum[spa_pkg::COEF_W] != wide_sum[spa_pkg::COEF_W-1]);
            if (wide_sum[spa_pkg::COEF_W] != wide_sum[spa_pkg::COEF_W-1]) begin
                sum_reg <= wide_sum[spa_pkg::COEF_W] ?
                           {1'b1, {(spa_pkg::COEF_W-1){1'b0}}} :
                           {1'b0, {(spa_pkg::COEF_W-1){1'b1}}};
            end else begin
                sum_reg <= wide_sum[spa_pkg::COEF_W-1:0];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.add_write && !found && !table_full) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (cmd.rotate) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // Output register: a finished beat waits here while the sequencer moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            // Only a read-out beat carries a term; every other beat closes its run.
            if (cmd.emit_kind == spa_pkg::EMIT_TERM) begin
                out_coef_reg <= cell_coef_reg[0];
                out_exp_reg  <= cell_exp_reg[0];
                out_last_reg <= status.read_last;
            end else begin
                out_coef_reg <= '0;
                out_exp_reg  <= '0;
                out_last_reg <= 1'b1;
            end
            case (cmd.emit_kind)
                spa_pkg::EMIT_ADD: begin
                    if (found) begin
                        out_status_reg <= sat_reg ? spa_pkg::ST_SAT : spa_pkg::ST_OK;
                    end else begin
                        out_status_reg <= table_full ? spa_pkg::ST_FULL : spa_pkg::ST_OK;
                    end
                end
                spa_pkg::EMIT_TERM:  out_status_reg <= spa_pkg::ST_OK;
                spa_pkg::EMIT_EMPTY: out_status_reg <= spa_pkg::ST_EMPTY;
                default:             out_status_reg <= spa_pkg::ST_OK;
            endcase
        end
    end

    assign status.table_empty = (count_reg == '0);
    assign status.read_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign status.spin_done   = (idx_reg == IDX_W'(MAX_TERMS - 1));
    assign status.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_exp_reg, out_coef_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[dv/sparse_polynomial_accumulator_unit_tb.sv]
// Self-checking testbench for the sparse polynomial accumulator: directed and random stream traffic.
`timescale 1ns / 1ps

module sparse_polynomial_accumulator_unit_tb;

    import spa_pkg::*;

    localparam int     TABLE_DEPTH = MAX_TERMS_DEFAULT;
    localparam longint COEF_MAX    = 64'sh0000_0000_7fff_ffff;
    localparam longint COEF_MIN    = -64'sh0000_0000_8000_0000;
    // A read-out keeps the cell chain rotating after its last beat until a full turn
    // is done, so the quiet time after draining covers that with margin.
    localparam int     SETTLE_CYCLES = 4 * TABLE_DEPTH + 10;

    // One add, read-out, clear or reserved command waiting to go out.
    typedef struct {
        op_t   op;
        coef_t coef;
        exp_t  ex;
    } poly_cmd_t;

    // One beat that the block owes on its result channel.
    typedef struct {
        coef_t   coef;
        exp_t    ex;
        status_t status;
        logic    last;
    } term_beat_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata  = '0;    // coefficient[31:0], exponent[39:32]
    logic [1:0]           s_tuser  = '0;    // op[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;          // term_coefficient[31:0], term_exponent[39:32]
    logic [1:0]           m_tuser;          // status[1:0]
    logic                 m_tlast;

    // Command backlog filled by the sequence below and drained by the driver.
    poly_cmd_t  cmd_backlog[$];
    poly_cmd_t  next_cmd;
    // Beats the block still owes, oldest first.
    term_beat_t owed_beats[$];
    term_beat_t want;

    // Shadow copy of the term table, kept in insertion order; the block keeps its cells sorted by exponent.
    coef_t term_coef_tbl [TABLE_DEPTH];
    exp_t  term_exp_tbl  [TABLE_DEPTH];
    int    term_total = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    sparse_polynomial_accumulator_unit #(
        .MAX_TERMS (TABLE_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic owe_beat(input coef_t coef, input exp_t ex, input status_t status,
                            input logic last);
        term_beat_t b;
        b.coef   = coef;
        b.ex     = ex;
        b.status = status;
        b.last   = last;
        owed_beats.push_back(b);
    endtask

    // Applies one accepted command to the shadow table and queues the beats it causes.
    task automatic accumulate_term(input op_t op, input coef_t coef, input exp_t ex);
        longint  sum;
        int      slot;
        int      emitted;
        int      i;
        int      e;
        status_t st;
        slot = -1;
        case (op)
            OP_ADD: begin
                for (i = 0; i < term_total; i++)
                    if (term_exp_tbl[i] == ex)
                        slot = i;
                if (slot >= 0) begin
                    // Existing term: saturating add, the clamp is reported.
                    sum = longint'(term_coef_tbl[slot]) + longint'(coef);
                    st  = ST_OK;
                    if (sum > COEF_MAX) begin
                        sum = COEF_MAX;
                        st  = ST_SAT;
                    end
                    if (sum < COEF_MIN) begin
                        sum = COEF_MIN;
                        st  = ST_SAT;
                    end
                    term_coef_tbl[slot] = coef_t'(sum);
                    owe_beat('0, '0, st, 1'b1);
                end else if (term_total >= TABLE_DEPTH) begin
                    owe_beat('0, '0, ST_FULL, 1'b1);
                end else begin
                    term_coef_tbl[term_total] = coef;
                    term_exp_tbl[term_total]  = ex;
                    term_total++;
                    owe_beat('0, '0, ST_OK, 1'b1);
                end
            end
            OP_READ: begin
                if (term_total == 0) begin
                    owe_beat('0, '0, ST_EMPTY, 1'b1);
                end else begin
                    // Exponents are distinct, so a scan from the top gives the order.
                    emitted = 0;
                    for (e = 255; e >= 0; e--) begin
                        for (i = 0; i < term_total; i++) begin
                            if (term_exp_tbl[i] == exp_t'(e)) begin
                                emitted++;
                                owe_beat(term_coef_tbl[i], term_exp_tbl[i], ST_OK,
                                         emitted == term_total);
                            end
                        end
                    end
                end
            end
            OP_CLEAR: begin
                term_total = 0;
                owe_beat('0, '0, ST_OK, 1'b1);
            end
            default: begin
                // The reserved op leaves the table alone and answers with a plain ok.
                owe_beat('0, '0, ST_OK, 1'b1);
            end
        endcase
    endtask

    task automatic push_cmd(input op_t op, input coef_t coef, input exp_t ex);
        poly_cmd_t c;
        c.op   = op;
        c.coef = coef;
        c.ex   = ex;
        cmd_backlog.push_back(c);
    endtask

    // Random commands, mostly adds. Half of the exponents come from a small pool so
    // that terms get hit again and the table fills up; coefficients lean toward large
    // magnitudes so that both saturation limits are reached.
    task automatic queue_random_cmds(input int count);
        int    n;
        int    pick;
        op_t   op;
        coef_t coef;
        exp_t  ex;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                op = OP_ADD;
            else if (pick < 86)
                op = OP_READ;
            else if (pick < 91)
                op = OP_CLEAR;
            else
                op = OP_RSVD;
            case ($urandom_range(3))
                0:       coef = coef_t'($urandom);
                1:       coef = coef_t'(int'($urandom_range(2 ** 20)) - 2 ** 19);
                2:       coef = coef_t'(32'h4000_0000 + $urandom_range(32'h3fff_ffff));
                default: coef = coef_t'(32'h8000_0000 + $urandom_range(32'h3fff_ffff));
            endcase
            if ($urandom_range(99) < 50)
                ex = exp_t'($urandom_range(19) * 13);
            else
                ex = exp_t'($urandom_range(255));
            push_cmd(op, coef, ex);
        end
    endtask

    // Holds the sequence until every queued command is taken and every owed beat has
    // come back, then lets the block finish any trailing rotation.
    task automatic settle();
        do
            @(negedge aclk);
        while (cmd_backlog.size() != 0 || s_tvalid || owed_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Driver: presents the next command when the slot is free and the gap draw allows.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                accumulate_term(op_t'(s_tuser), coef_t'(s_tdata[31:0]), s_tdata[39:32]);
            if (!s_tvalid || s_tready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_cmd.ex, next_cmd.coef};
                    s_tuser  <= next_cmd.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: every accepted result beat is checked against the oldest owed beat.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_beats.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat coef=%h exp=%0d status=%0d last=%b",
                                        m_tdata[31:0], m_tdata[39:32], m_tuser, m_tlast));
            end else begin
                want = owed_beats.pop_front();
                if (m_tdata[31:0] !== want.coef)
                    flag_mismatch($sformatf("term_coefficient %h, expected %h",
                                            m_tdata[31:0], want.coef));
                if (m_tdata[39:32] !== want.ex)
                    flag_mismatch($sformatf("term_exponent %0d, expected %0d",
                                            m_tdata[39:32], want.ex));
                if (m_tuser !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
                if (m_tlast !== want.last)
                    flag_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
            end
        end
    end

    // Main sequence: reset, directed commands, then four random phases with
    // different idling, draining the block completely between phases.
    initial begin
        int k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Phase with no idling on either side, starting with the directed commands.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_cmd(OP_READ, coef_t'(32'hffff_ffff), 8'hff);        // read-out of an empty table
        push_cmd(OP_RSVD, coef_t'(32'h1234_5678), 8'h5a);        // reserved op is ignored
        push_cmd(OP_ADD,  coef_t'(32'h7fff_ffff), 8'd255);       // largest coefficient, top exponent
        push_cmd(OP_ADD,  coef_t'(32'h0000_0001), 8'd255);       // clamps at the upper limit
        push_cmd(OP_ADD,  coef_t'(32'h8000_0000), 8'd0);         // most negative, exponent zero
        push_cmd(OP_ADD,  coef_t'(32'h8000_0000), 8'd0);         // clamps at the lower limit
        push_cmd(OP_ADD,  coef_t'(-32'sd327680), 8'd7);
        push_cmd(OP_ADD,  coef_t'(32'sd327680), 8'd7);           // sums to zero, term stays
        for (k = 0; k < TABLE_DEPTH - 3; k++)
            push_cmd(OP_ADD, (k % 2) ? coef_t'(32'ha5a5_0000 ^ k) : coef_t'(32'h5a5a_ffff),
                     exp_t'(k * 17 + 3));
        push_cmd(OP_ADD,   coef_t'(32'h0001_0000), 8'd100);      // table full, term dropped
        push_cmd(OP_READ,  '0, '0);                               // full table, sorted
        push_cmd(OP_CLEAR, coef_t'(32'hdead_beef), 8'h81);
        push_cmd(OP_READ,  '0, '0);                               // empty again after clear
        queue_random_cmds(40);
        settle();

        // Sender idles most of the time.
        send_idle_pct  = 78;
        recv_stall_pct = 0;
        queue_random_cmds(50);
        settle();

        // Receiver stalls most of the time.
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        queue_random_cmds(50);
        settle();

        // Both sides pause now and then.
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        queue_random_cmds(50);
        settle();

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
design/spa_pkg.sv
design/spa_ctrl.sv
design/spa_datapath.sv
design/sparse_polynomial_accumulator_unit.sv
dv/sparse_polynomial_accumulator_unit_tb.sv
